// ===== sv/assert_macros.svh =====
// assertion macros used by acmac_aes_core
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_PROP(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define AST_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define AST_PROP(label, clk, rst, expr)
`define AST_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== sv/acmac_pkg.sv =====
// types, constants and aes helper functions of the cmac tag engine
// no dependencies; used by every module of the block
package acmac_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int AES_ROUNDS = 10;

   localparam logic [1:0] CMD_ABSORB  = 2'd0;
   localparam logic [1:0] CMD_FINISH  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam logic [0:0] REG_KEY_UPPER = 1'b0;
   localparam logic [0:0] REG_KEY_LOWER = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [127:0] GF_POLY = 128'h87;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_upper;
      logic [63:0] tag_lower;
   } rsp_type;

   typedef struct packed {
      logic         start;
      logic [127:0] block;
   } aes_cmd_type;

   typedef struct packed {
      logic         done;
      logic [127:0] block;
   } aes_res_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // sub bytes, shift rows and, except in the last round, mix columns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, e;
      logic [127:0] r;
      for (int k = 0; k < 16; k++) begin
         b[k] = s[127 - 8 * k -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            t[j + 4 * c] = SBOX[b[j + 4 * ((c + j) & 3)]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            e = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ e ^ xt(a0 ^ a1);
            t[4 * c + 1] = a1 ^ e ^ xt(a1 ^ a2);
            t[4 * c + 2] = a2 ^ e ^ xt(a2 ^ a3);
            t[4 * c + 3] = a3 ^ e ^ xt(a3 ^ a0);
         end
      end
      for (int k = 0; k < 16; k++) begin
         r[127 - 8 * k -: 8] = t[k];
      end
      return r;
   endfunction

   function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] t, w0, w1, w2, w3;
      t = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0 = rk[127:96] ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? GF_POLY : 128'h0);
   endfunction

   // byte b placed at block position pos, byte 0 in the top bits
   function automatic logic [127:0] place_byte(input logic [3:0] pos, input logic [7:0] b);
      return {120'h0, b} << {4'hf - pos, 3'b000};
   endfunction

endpackage

// ===== sv/acmac_front.sv =====
// front part: accepts request items, drops unused commands, queues the rest
// depends on acmac_pkg
module acmac_front #(
   parameter int QUEUE_DEPTH = acmac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  acmac_pkg::req_type req_data,
   output logic               q_valid,
   output acmac_pkg::req_type q_item,
   input  logic               q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   acmac_pkg::req_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item = entries_ff[rd_ptr_ff];
   assign pop = q_pop && q_valid;
   // command 3 is a no-op and never enters the queue
   assign push = req_valid && req_ready && (req_data.command != acmac_pkg::CMD_UNUSED);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

// ===== sv/acmac_aes_core.sv =====
// iterative aes-128 encryption core, one round per cycle, keys expanded on the fly
// depends on acmac_pkg and assert_macros.svh
`include "assert_macros.svh"
module acmac_aes_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [127:0]           key,
   input  acmac_pkg::aes_cmd_type cmd,
   output acmac_pkg::aes_res_type res
);

   localparam logic [3:0] LAST = 4'(acmac_pkg::AES_ROUNDS);

   logic [127:0] s_ff, s_in, rk_ff, rk_in, next_rk;
   logic [7:0] rcon_ff, rcon_in;
   logic [3:0] round_ff, round_in;
   logic busy_ff, busy_in, done_ff, done_in;

   assign next_rk = acmac_pkg::key_expand(rk_ff, rcon_ff);
   assign res.done = done_ff;
   assign res.block = s_ff;

   always_comb begin
      s_in = s_ff;
      rk_in = rk_ff;
      rcon_in = rcon_ff;
      round_in = round_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         s_in = acmac_pkg::aes_round(s_ff, round_ff == LAST) ^ next_rk;
         rk_in = next_rk;
         rcon_in = acmac_pkg::xt(rcon_ff);
         round_in = round_ff + 1'b1;
         if (round_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         s_in = cmd.block ^ key;
         rk_in = key;
         rcon_in = 8'h01;
         round_in = 4'd1;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         round_ff <= 4'd1;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      rk_ff <= rk_in;
      rcon_ff <= rcon_in;
   end

   `AST_PROP(a_no_start_busy, clock, reset, !(cmd.start && busy_ff))
   `AST_PROP(a_done_not_busy, clock, reset, !(done_ff && busy_ff))
   `AST_NEXT(a_done_after_last, clock, reset, busy_ff && round_ff == LAST, done_ff && !busy_ff)

endmodule

// ===== sv/acmac_back.sv =====
// back part: chaining block, subkey derivation, tag output register
// depends on acmac_pkg; drives the aes core
module acmac_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  acmac_pkg::req_type     q_item,
   output logic                   q_pop,
   output acmac_pkg::aes_cmd_type aes_cmd,
   input  acmac_pkg::aes_res_type aes_res,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output acmac_pkg::rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHAIN  = 4'b0010,
      S_SUBKEY = 4'b0100,
      S_TAG    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [127:0] chain_ff, chain_in, sub_key;
   logic [3:0] fill_ff, fill_in;
   logic seen_ff, seen_in, k2_ff, k2_in;
   logic [7:0] hold_ff, hold_in;
   logic rsp_valid_ff, rsp_valid_in;
   acmac_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      sub_key = acmac_pkg::gf_double(aes_res.block);
      if (k2_ff) begin
         sub_key = acmac_pkg::gf_double(sub_key);
      end
   end

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      fill_in = fill_ff;
      seen_in = seen_ff;
      k2_in = k2_ff;
      hold_in = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      q_pop = 1'b0;
      aes_cmd.start = 1'b0;
      aes_cmd.block = chain_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_item.command)
                  acmac_pkg::CMD_ABSORB: begin
                     q_pop = 1'b1;
                     if (seen_ff && fill_ff == 4'd0) begin
                        // full block is encrypted before this byte goes in
                        aes_cmd.start = 1'b1;
                        hold_in = q_item.data_byte;
                        state_in = S_CHAIN;
                     end else begin
                        chain_in = chain_ff ^ acmac_pkg::place_byte(fill_ff, q_item.data_byte);
                        fill_in = fill_ff + 1'b1;
                        seen_in = 1'b1;
                     end
                  end
                  acmac_pkg::CMD_FINISH: begin
                     // wait until the output register is free
                     if (!rsp_valid_ff) begin
                        q_pop = 1'b1;
                        aes_cmd.start = 1'b1;
                        aes_cmd.block = '0;
                        k2_in = (fill_ff != 4'd0) || !seen_ff;
                        if ((fill_ff != 4'd0) || !seen_ff) begin
                           chain_in = chain_ff ^ acmac_pkg::place_byte(fill_ff, acmac_pkg::PAD_BYTE);
                        end
                        state_in = S_SUBKEY;
                     end
                  end
                  acmac_pkg::CMD_RESTART: begin
                     q_pop = 1'b1;
                     chain_in = '0;
                     fill_in = '0;
                     seen_in = 1'b0;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         S_CHAIN: begin
            if (aes_res.done) begin
               chain_in = aes_res.block ^ acmac_pkg::place_byte(4'd0, hold_ff);
               fill_in = 4'd1;
               seen_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SUBKEY: begin
            if (aes_res.done) begin
               aes_cmd.start = 1'b1;
               aes_cmd.block = sub_key ^ chain_ff;
               state_in = S_TAG;
            end
         end
         S_TAG: begin
            if (aes_res.done) begin
               rsp_data_in.tag_upper = aes_res.block[127:64];
               rsp_data_in.tag_lower = aes_res.block[63:0];
               rsp_valid_in = 1'b1;
               chain_in = '0;
               fill_in = '0;
               seen_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chain_ff <= '0;
         fill_ff <= '0;
         seen_ff <= 1'b0;
         k2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         fill_ff <= fill_in;
         seen_ff <= seen_in;
         k2_ff <= k2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sv/aes_cmac_tag_engine_top.sv =====
// top level of the aes-128 cmac tag engine: key registers, front queue, back, aes core
// depends on acmac_pkg, acmac_front, acmac_back, acmac_aes_core
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   acmac_pkg::req_type (command, data_byte)
//   rsp      out        rsp_valid / rsp_ready   acmac_pkg::rsp_type (tag_upper, tag_lower)
//   csr      in         csr_write_enable        csr_index, csr_write_data (key halves)
//
// an absorb item goes straight into the chaining block, except the byte after each full
// block, which waits while the iterative aes core (one round per cycle) encrypts it
// a finish item runs the core twice (subkey, then tag) to fill the output register
// the queue of QUEUE_DEPTH items lets the front accept while the back encrypts
// a finish waits while an earlier tag is still not taken; reset is synchronous
module aes_cmac_tag_engine_top #(
   parameter int QUEUE_DEPTH = acmac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  acmac_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output acmac_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [63:0]        csr_write_data
);

   logic [63:0] key_upper_ff, key_lower_ff;
   logic q_valid, q_pop;
   acmac_pkg::req_type q_item;
   acmac_pkg::aes_cmd_type aes_cmd;
   acmac_pkg::aes_res_type aes_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            acmac_pkg::REG_KEY_UPPER: key_upper_ff <= csr_write_data;
            acmac_pkg::REG_KEY_LOWER: key_lower_ff <= csr_write_data;
            default: key_upper_ff <= key_upper_ff;
         endcase
      end
   end

   acmac_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   acmac_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .aes_cmd(aes_cmd),
      .aes_res(aes_res),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   acmac_aes_core u_aes (
      .clock(clock),
      .reset(reset),
      .key({key_upper_ff, key_lower_ff}),
      .cmd(aes_cmd),
      .res(aes_res)
   );

endmodule
